[hdl/ssnf_pkg.sv]
// ----------------------------------------------------------------------------
// ssnf_pkg
// Shared widths, segment fonts and the radix power table for the formatter.
// ----------------------------------------------------------------------------
package ssnf_pkg;

  localparam int MAG_W              = 32;  // magnitude width
  localparam int POW_W              = 33;  // radix powers, saturated at 2^32
  localparam int QBITS              = 4;   // quotient bits per digit (radix <= 16)
  localparam int DIV_W              = POW_W + QBITS - 1;
  localparam int MAX_DIGITS         = 8;
  localparam int NUMERIC_DIGITS_DEF = 4;
  localparam int DIGIT_SLOTS        = 4;   // slots 4, 3, 1, 0 from the right
  localparam int SEG_W              = 8;
  localparam int BASE_W             = 5;

  localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  // control bits travelling down the pipe beside the data
  typedef struct packed {
    logic valid;
    logic neg;
    logic ovf;
  } tag_t;

  typedef logic [MAX_DIGITS:0][POW_W-1:0] pow_row_t;
  typedef pow_row_t [16:0]                pow_tbl_t;

  // base^k, saturated at 2^32; rows below 2 are never read
  function automatic pow_tbl_t build_pow_tbl();
    pow_tbl_t tbl;
    longint   p;
    tbl = '0;
    for (int b = 0; b <= 16; b++) begin
      p = 1;
      for (int k = 0; k <= MAX_DIGITS; k++) begin
        tbl[b][k] = POW_W'(p);
        p = p * b;
        if (p > 64'sh1_0000_0000) p = 64'sh1_0000_0000;
      end
    end
    return tbl;
  endfunction

  localparam pow_tbl_t POW_TBL = build_pow_tbl();

  // 0-9, then a B C d E F
  function automatic logic [SEG_W-1:0] glyph(input logic [QBITS-1:0] d);
    logic [SEG_W-1:0] seg;
    case (d)
      4'h0:    seg = 8'h3F;
      4'h1:    seg = 8'h06;
      4'h2:    seg = 8'h5B;
      4'h3:    seg = 8'h4F;
      4'h4:    seg = 8'h66;
      4'h5:    seg = 8'h6D;
      4'h6:    seg = 8'h7D;
      4'h7:    seg = 8'h07;
      4'h8:    seg = 8'h7F;
      4'h9:    seg = 8'h6F;
      4'hA:    seg = 8'h5F;
      4'hB:    seg = 8'h7C;
      4'hC:    seg = 8'h39;
      4'hD:    seg = 8'h5E;
      4'hE:    seg = 8'h79;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

endpackage

[hdl/seven_segment_number_formatter.sv]
// ----------------------------------------------------------------------------
// seven_segment_number_formatter
// Signed integer to segment bytes for a five-slot display (digits, colon,
// digits), right-aligned in a programmable radix of 2 to 16.
//
// One request is taken every clock cycle while the skid entry is empty. The
// depth is set by the digit extractor: long division by the radix powers,
// one quotient bit per pipeline stage, four stages per digit.
// Three stages in front register the input, take the magnitude and check it
// against the digit budget. A two-entry output buffer lets the pipe keep
// running after the sink stalls until the skid entry fills; s_axis_tready is
// a register.
// Write number_base only while no request is in flight.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter #(
  parameter int NUMERIC_DIGITS = ssnf_pkg::NUMERIC_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration: number_base, saturated to 2..16 on write
  input  logic                         cfg_wr_en,
  input  logic [ssnf_pkg::BASE_W-1:0]  cfg_wr_data,
  // request in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // [31:0] value
  // result out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] slot0, [15:8] slot1, [23:16] colon, [31:24] slot3, [39:32] slot4
  output logic [39:0]                  m_axis_tdata,
  output logic                         m_axis_tuser   // [0] overflow
);
  import ssnf_pkg::*;

  localparam int QW    = QBITS * NUMERIC_DIGITS;
  localparam int NSTEP = QW;

  // ---------------- configuration ----------------
  logic [BASE_W-1:0] base_q;
  logic [BASE_W-1:0] base_next;

  always_comb begin
    if (cfg_wr_data < BASE_MIN)      base_next = BASE_MIN;
    else if (cfg_wr_data > BASE_MAX) base_next = BASE_MAX;
    else                             base_next = cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_q <= BASE_RESET;
    end else if (cfg_wr_en) begin
      base_q <= base_next;
    end
  end

  // ---------------- flow control ----------------
  // whole pipe moves together; it only freezes once the skid entry is full
  logic skid_valid;
  logic advance;

  assign advance       = !skid_valid;
  assign s_axis_tready = advance;

  // ---------------- front stages ----------------
  tag_t             tag1, tag2, tag3;
  logic [MAG_W-1:0] raw1, mag2, mag3;
  logic [POW_W-1:0] lim_pos, lim_neg, lim;

  // digit budget: base^N, one digit fewer when negative
  assign lim_pos = POW_TBL[base_q][NUMERIC_DIGITS];
  assign lim_neg = POW_TBL[base_q][NUMERIC_DIGITS-1];
  assign lim     = tag2.neg ? lim_neg : lim_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else if (advance) begin
      tag1.valid <= s_axis_tvalid;
      tag1.neg   <= s_axis_tdata[MAG_W-1];
      tag1.ovf   <= 1'b0;
      tag2       <= tag1;
      tag3.valid <= tag2.valid;
      tag3.neg   <= tag2.neg;
      tag3.ovf   <= POW_W'(mag2) >= lim;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw1 <= s_axis_tdata;
      // most negative value wraps to 2^31, which is its true magnitude
      mag2 <= tag1.neg ? (MAG_W'(0) - raw1) : raw1;
      mag3 <= mag2;
    end
  end

  // ---------------- digit extraction ----------------
  // most significant digit first; digit k ends up in quot[4k+3:4k]
  tag_t             tag_p  [0:NSTEP];
  logic [MAG_W-1:0] rem_p  [0:NSTEP];
  logic [QW-1:0]    quot_p [0:NSTEP];

  assign tag_p[0]  = tag3;
  assign rem_p[0]  = mag3;
  assign quot_p[0] = '0;

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int K  = NUMERIC_DIGITS - 1 - j / QBITS;
    localparam int SH = QBITS - 1 - j % QBITS;

    ssnf_div_step #(
      .QW    (QW),
      .SHIFT (SH)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .tag_in   (tag_p[j]),
      .rem_in   (rem_p[j]),
      .quot_in  (quot_p[j]),
      .pow      (POW_TBL[base_q][K]),
      .tag_out  (tag_p[j+1]),
      .rem_out  (rem_p[j+1]),
      .quot_out (quot_p[j+1])
    );
  end

  // ---------------- formatting ----------------
  tag_t                                tag_f;
  logic [QW-1:0]                       quot_f;
  logic [DIGIT_SLOTS-1:0]              shown;      // digit k is printed
  logic [DIGIT_SLOTS-1:0][SEG_W-1:0]   dig_seg;
  logic [DIGIT_SLOTS-1:0][SEG_W-1:0]   slot_seg;   // index 0 = rightmost
  logic [39:0]                         fmt_data;
  logic                                incoming;

  assign tag_f  = tag_p[NSTEP];
  assign quot_f = quot_p[NSTEP];

  for (genvar k = 0; k < DIGIT_SLOTS; k++) begin : g_slot
    if (k == 0) begin : g_units
      assign shown[k]   = 1'b1;  // zero still shows a single 0
      assign dig_seg[k] = glyph(quot_f[QBITS-1:0]);
    end else if (k < NUMERIC_DIGITS) begin : g_dig
      // printed when it or any higher digit is non-zero
      assign shown[k]   = quot_f[QW-1:QBITS*k] != '0;
      assign dig_seg[k] = glyph(quot_f[QBITS*k +: QBITS]);
    end else begin : g_none
      assign shown[k]   = 1'b0;
      assign dig_seg[k] = SEG_BLANK;
    end
  end

  always_comb begin
    for (int k = 0; k < DIGIT_SLOTS; k++) begin
      if (tag_f.ovf)     slot_seg[k] = SEG_MINUS;
      else if (shown[k]) slot_seg[k] = dig_seg[k];
      else               slot_seg[k] = SEG_BLANK;
    end
    // minus goes just left of the top digit
    for (int k = 1; k < DIGIT_SLOTS; k++) begin
      if (!tag_f.ovf && tag_f.neg && !shown[k] && shown[k-1]) slot_seg[k] = SEG_MINUS;
    end
  end

  assign fmt_data = {slot_seg[0], slot_seg[1], SEG_BLANK, slot_seg[2], slot_seg[3]};
  assign incoming = tag_f.valid && advance;

  // ---------------- output register and skid entry ----------------
  logic        out_valid;
  logic [39:0] out_data, skid_data;
  logic        out_ovf, skid_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= incoming;
      end
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_ovf  <= skid_ovf;
      end else begin
        out_data <= fmt_data;
        out_ovf  <= tag_f.ovf;
      end
    end else if (incoming) begin
      skid_data <= fmt_data;
      skid_ovf  <= tag_f.ovf;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_ovf;

endmodule

[hdl/ssnf_div_step.sv]
// ----------------------------------------------------------------------------
// ssnf_div_step
// One restoring-division step: a compare and subtract against a shifted
// radix power, yielding one quotient bit. Registered.
// ----------------------------------------------------------------------------
module ssnf_div_step #(
  parameter int QW    = 16,
  parameter int SHIFT = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  ssnf_pkg::tag_t              tag_in,
  input  logic [ssnf_pkg::MAG_W-1:0]  rem_in,
  input  logic [QW-1:0]               quot_in,
  input  logic [ssnf_pkg::POW_W-1:0]  pow,
  output ssnf_pkg::tag_t              tag_out,
  output logic [ssnf_pkg::MAG_W-1:0]  rem_out,
  output logic [QW-1:0]               quot_out
);
  import ssnf_pkg::*;

  logic [DIV_W-1:0] divisor;
  logic [DIV_W-1:0] rem_ext;
  logic [DIV_W-1:0] diff;
  logic             take;

  assign divisor = DIV_W'(pow) << SHIFT;
  assign rem_ext = DIV_W'(rem_in);
  assign take    = rem_ext >= divisor;
  assign diff    = rem_ext - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (en) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? diff[MAG_W-1:0] : rem_in;
      quot_out <= {quot_in[QW-2:0], take};
    end
  end

endmodule

[hdl/ssnf_checker.sv]
// ----------------------------------------------------------------------------
// ssnf_checker
// Port-level checks on the formatter's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ssnf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [39:0]                  m_axis_tdata,
  input logic                         m_axis_tuser
);
  import ssnf_pkg::*;

  // colon slot never lights
  a_colon_blank: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:16] == SEG_BLANK)
    else $error("colon slot not blank");

  // overflow shows dashes in all four digit slots
  a_ovf_dashes: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[7:0] == SEG_MINUS) && (m_axis_tdata[15:8] == SEG_MINUS) &&
      (m_axis_tdata[31:24] == SEG_MINUS) && (m_axis_tdata[39:32] == SEG_MINUS))
    else $error("overflow without dashes");

  // a fitting number always has its units digit
  a_units_lit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata[39:32] != SEG_BLANK) && (m_axis_tdata[39:32] != SEG_MINUS))
    else $error("units slot not a digit");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed under stall");

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (.*);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for seven_segment_number_formatter. Signed values are
// streamed in under a range of radix settings (in range, out of range and
// saturating), with random idling on both sides, and every result is
// compared slot by slot against a behavioural prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssnf_pkg::*;

  localparam int DIGITS      = 4;    // digit budget of the instance
  localparam int LATENCY     = 3 + 4 * DIGITS + 1;
  localparam int PHASE_ITEMS = 138;
  localparam int HOLD_CYCLES = 300;  // long sink hold-off, fills the pipe

  // segment font, 0-9 then a B C d E F
  localparam logic [7:0] DIGIT_FONT [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h5F, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };
  localparam logic [7:0] SEG_DASH = 8'h40;
  localparam logic [7:0] SEG_OFF  = 8'h00;

  // radix per random phase: reset value, extremes, saturating codes, odd ones
  localparam int PHASE_COUNT = 12;
  localparam logic [4:0] PHASE_BASE [PHASE_COUNT] = '{
    5'd10, 5'd2, 5'd16, 5'd3, 5'd7, 5'd0, 5'd31, 5'd1, 5'd17, 5'd12, 5'd9, 5'd5
  };

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] slot0;
    logic [7:0] slot1;
    logic [7:0] colon;
    logic [7:0] slot3;
    logic [7:0] slot4;
    logic       ovf;
  } display_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the radix and a FIFO of expected
  // displays, one per accepted request.
  // --------------------------------------------------------------------------
  class display_scoreboard;
    logic [4:0] radix_reg;
    display_t   expected_displays[$];
    int         errors;
    int         checked;
    int         overflows;

    function new();
      radix_reg = BASE_RESET;
      errors    = 0;
      checked   = 0;
      overflows = 0;
    endfunction

    function void set_radix(logic [4:0] b);
      radix_reg = b;
    endfunction

    // codes outside 2..16 saturate
    function int radix();
      if (radix_reg < 5'd2) return 2;
      if (radix_reg > 5'd16) return 16;
      return int'(radix_reg);
    endfunction

    // first magnitude that no longer fits; one digit less when negative
    function longint digit_limit(logic neg);
      longint lim;
      int     n;
      lim = 1;
      n   = neg ? DIGITS - 1 : DIGITS;
      for (int i = 0; i < n; i++) begin
        if (lim <= 64'h0_FFFF_FFFF) lim = lim * radix();
      end
      return lim;
    endfunction

    function display_t format_value(logic [31:0] raw);
      display_t   d;
      logic [7:0] slots [5];
      logic       neg;
      logic [31:0] mag;
      int         b;
      int         pos;
      neg = raw[31];
      mag = neg ? -raw : raw;   // 2^31 comes out exact as an unsigned value
      b   = radix();
      for (int i = 0; i < 5; i++) slots[i] = SEG_OFF;
      d.ovf = (longint'({32'd0, mag}) >= digit_limit(neg));
      if (d.ovf) begin
        slots[0] = SEG_DASH;
        slots[1] = SEG_DASH;
        slots[3] = SEG_DASH;
        slots[4] = SEG_DASH;
      end else begin
        // right-aligned, stepping over the colon
        pos = 4;
        do begin
          if (pos >= 0) slots[pos] = DIGIT_FONT[4'(mag % 32'(b))];
          pos--;
          if (pos == 2) pos--;
          mag = mag / 32'(b);
        end while (mag != 32'd0);
        if (neg && pos >= 0) slots[pos] = SEG_DASH;
      end
      d.slot0 = slots[0];
      d.slot1 = slots[1];
      d.colon = slots[2];
      d.slot3 = slots[3];
      d.slot4 = slots[4];
      return d;
    endfunction

    function void note_request(logic [31:0] value);
      expected_displays.push_back(format_value(value));
    endfunction

    function int pending();
      return expected_displays.size();
    endfunction

    function void check_result(logic [39:0] data, logic user);
      display_t exp_d;
      if (expected_displays.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b", data, user);
        errors++;
        return;
      end
      exp_d = expected_displays.pop_front();
      checked++;
      if (exp_d.ovf) overflows++;
      if (data[7:0] !== exp_d.slot0) begin
        $error("slot0_segments: expected %h, got %h", exp_d.slot0, data[7:0]);
        errors++;
      end
      if (data[15:8] !== exp_d.slot1) begin
        $error("slot1_segments: expected %h, got %h", exp_d.slot1, data[15:8]);
        errors++;
      end
      if (data[23:16] !== exp_d.colon) begin
        $error("colon_segments: expected %h, got %h", exp_d.colon, data[23:16]);
        errors++;
      end
      if (data[31:24] !== exp_d.slot3) begin
        $error("slot3_segments: expected %h, got %h", exp_d.slot3, data[31:24]);
        errors++;
      end
      if (data[39:32] !== exp_d.slot4) begin
        $error("slot4_segments: expected %h, got %h", exp_d.slot4, data[39:32]);
        errors++;
      end
      if (user !== exp_d.ovf) begin
        $error("overflow: expected %b, got %b", exp_d.ovf, user);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = 5'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'd0;     // [31:0] value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] slot0, [15:8] slot1, [23:16] colon, [31:24] slot3, [39:32] slot4
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;             // [0] overflow

  always #1 clk = ~clk;

  seven_segment_number_formatter #(
    .NUMERIC_DIGITS(DIGITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  display_scoreboard sb = new();

  int send_idle_pct  = 0;  // chance per cycle that the source holds back
  int recv_stall_pct = 0;  // chance per cycle that the sink drops tready
  int recv_hold      = 0;  // forced sink hold-off, counted down below
  int requests_sent  = 0;
  int phases_run     = 0;

  // --------------------------------------------------------------------------
  // Sink: checks each accepted result against the oldest expectation and
  // picks tready for the next edge. Inputs sampled just after the edge see
  // the values from before it, so there is no race with the DUT's flops.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Source tasks
  // --------------------------------------------------------------------------

  // One request. tvalid is left high afterwards so that back-to-back
  // requests see a single assignment per edge; gaps lower it.
  task automatic send_value(input logic [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(v);
    requests_sent++;
  endtask

  // Source goes quiet until every expected display has been seen.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Radix write; only called once the pipe is empty.
  task automatic write_radix(input logic [4:0] b);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_radix(b);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 50; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default:   begin send_idle_pct = 34; recv_stall_pct = 34; end
    endcase
  endtask

  // Mostly values that fit the current radix, with the digit budget's edge
  // hit often, and a share of full 32-bit noise to toggle every bit.
  function automatic logic [31:0] pick_value();
    logic        neg;
    longint      lim;
    logic [31:0] mag;
    int          kind;
    kind = $urandom_range(0, 9);
    neg  = 1'($urandom_range(0, 1));
    lim  = sb.digit_limit(neg);
    if (kind < 6)
      mag = 32'($urandom_range(0, int'(lim - 1)));
    else if (kind < 8)
      mag = 32'(lim) + 32'($urandom_range(0, 2)) - 32'd1;
    else
      return $urandom();
    return neg ? -mag : mag;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, at the reset radix of ten: zero, smallest and largest
    // magnitudes, the digit budget either side for both signs, and the
    // most negative value.
    send_value(32'd0);
    send_value(32'd1);
    send_value(-32'sd1);
    send_value(32'd9999);
    send_value(32'd10000);
    send_value(-32'sd999);
    send_value(-32'sd1000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(-32'sd42);
    drain();

    // hex: every letter glyph, budget edges
    write_radix(5'd16);
    send_value(32'h0000_ABCD);
    send_value(32'h0000_EF98);
    send_value(32'h0000_FFFF);
    send_value(32'h0001_0000);
    send_value(-32'sh0FFF);
    send_value(-32'sh1000);
    drain();

    // binary: budget edges
    write_radix(5'd2);
    send_value(32'd15);
    send_value(32'd16);
    send_value(-32'sd7);
    send_value(-32'sd8);
    drain();

    // out-of-range codes saturate to 2 and 16
    write_radix(5'd0);
    send_value(32'd5);
    drain();
    write_radix(5'd31);
    send_value(32'h0000_00EF);
    send_value(-32'sh0ABC);
    drain();

    // Random phases; the first one runs at the reset radix once more.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_radix(PHASE_BASE[ph]);
      set_idling(idle_mode_t'(ph % 4));
      // sink holds off for a long stretch while the source keeps offering,
      // so the pipe fills and tready drops
      if (ph == 1) recv_hold = HOLD_CYCLES;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // source pauses mid-phase until everything outstanding has come back
        if (ph == 2 && i == PHASE_ITEMS / 2) drain();
        send_value(pick_value());
      end
      drain();
      phases_run++;
    end

    set_idling(IDLE_NONE);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Summary: %0d requests over %0d random phases and several radix settings",
             requests_sent, phases_run);
    $display("Summary: %0d displays checked, %0d of them overflow dashes",
             sb.checked, sb.overflows);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("timeout with %0d displays outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
hdl/ssnf_pkg.sv
hdl/ssnf_div_step.sv
hdl/seven_segment_number_formatter.sv
hdl/ssnf_checker.sv
sim/tb.sv
